// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ----- hdl/pngu_pkg.sv -----
// ----------------------------------------------------------------------------
// PNG unfilter package
// Widths, row filter codes and configuration register indices.
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BPP_W     = 3;
    localparam int unsigned ROW_LEN_W = 15;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 15;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP     = 1'b0,
        CFG_ROW_LEN = 1'b1
    } cfg_index_t;

endpackage

// ----- hdl/pngu_raw_if.sv -----
// ----------------------------------------------------------------------------
// PNG unfilter input channel
// Inflated stream bytes with an image start mark.
// ----------------------------------------------------------------------------
interface pngu_raw_if;
    logic                          valid;
    logic                          ready;
    logic [pngu_pkg::BYTE_W-1:0]   raw_byte;
    logic                          image_start;

    modport source (output valid, output raw_byte, output image_start, input ready);
    modport sink   (input valid, input raw_byte, input image_start, output ready);
endinterface

// ----- hdl/pngu_pix_if.sv -----
// ----------------------------------------------------------------------------
// PNG unfilter output channel
// Reconstructed bytes with row end and error marks.
// ----------------------------------------------------------------------------
interface pngu_pix_if;
    logic                          valid;
    logic                          ready;
    logic [pngu_pkg::BYTE_W-1:0]   pixel_byte;
    logic                          row_end;
    logic                          bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                    output ready);
endinterface

// ----- hdl/pngu_cfg_if.sv -----
// ----------------------------------------------------------------------------
// PNG unfilter configuration channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface pngu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pngu_pkg::CFG_IDX_W-1:0]   index;
    logic [pngu_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/png_scanline_unfilter.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs 8-bit PNG rows (None/Sub/Up/Average/Paeth) from the inflated
// byte stream, keeping the previous row in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   raw  - sink of stream bytes; image_start marks the filter byte opening an
//          image. Valid filter bytes give no result; each data byte gives one.
//   pix  - source of reconstructed bytes, row_end on the last byte of a row,
//          bad_filter (pixel 0) once for a filter type above 4, after which
//          bytes are dropped until the next image_start.
//   cfg  - register writes (0: bytes per pixel, 1: row length); always ready,
//          write only while the block is idle.
// Pipeline: the accepting edge reads the prior-row memory and loads the stage;
//   the output register then takes the reconstructed byte.
// Throughput: one byte per cycle unless pix stalls, set by the single read of the
//   prior-row memory per data byte and the left-neighbour feedback.
// Reset: control state cleared, registers back to 1/1; prior-row memory is not
//   cleared and needs no clearing pass.
// Stall: the output register holds while pix.ready is low; the stage behind
//   it takes one more request if it is empty, then raw.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module png_scanline_unfilter #(
    parameter int unsigned MAX_ROW_BYTES = 16384
) (
    input  logic clk,
    input  logic rst_n,
    pngu_raw_if.sink   raw,
    pngu_pix_if.source pix,
    pngu_cfg_if.sink   cfg
);

    localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
    localparam int unsigned LW = (AW + 1 > pngu_pkg::ROW_LEN_W) ? AW + 1 : pngu_pkg::ROW_LEN_W;
    localparam int unsigned BW = pngu_pkg::BYTE_W;

    typedef struct packed {
        logic                  is_data;
        logic [BW-1:0]         raw_byte;
        pngu_pkg::filter_t     filt;
        logic [AW-1:0]         x;
        logic                  last;
        logic                  first_row;
        logic                  use_left;
        logic [1:0]            sel;
    } stage_t;

    // configuration
    logic [pngu_pkg::BPP_W-1:0]     bpp_reg;
    logic [pngu_pkg::ROW_LEN_W-1:0] row_len_reg;

    // row tracking
    logic              halted_reg, halted_next;
    logic              expect_reg, expect_next;
    logic              first_row_reg, first_row_next;
    pngu_pkg::filter_t filter_reg, filter_next;
    logic [AW-1:0]     col_reg, col_next;

    // stage between memory read and reconstruction
    logic    stg_valid_reg, stg_valid_next;
    stage_t  stg_reg, stg_next;
    logic    stg_load;
    logic    advance;
    logic [BW-1:0] rd_data_reg;

    logic [31:0] left_bytes_reg;
    logic [31:0] up_left_bytes_reg;

    // output register
    logic          pix_valid_reg, pix_valid_next;
    logic [BW-1:0] pix_byte_reg;
    logic          pix_end_reg;
    logic          pix_bad_reg;

    logic [BW-1:0] prior_row [MAX_ROW_BYTES];

    logic                       accept;
    logic                       eff_halted, eff_expect, eff_first;
    logic [pngu_pkg::BPP_W-1:0] bpp_c;
    logic [LW-1:0]              len_c, len_ext, x_plus;
    logic                       last_c;

    logic [BW-1:0] up_b, left_b, up_left_b, pred, val;
    logic [BW:0]   avg_sum;
    logic [BW-1:0] pa, pb;
    logic [BW+1:0] pc, ab_sum, cc_sum;
    logic [BW-1:0] paeth;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= pngu_pkg::BPP_W'(1);
            row_len_reg <= pngu_pkg::ROW_LEN_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (pngu_pkg::cfg_index_t'(cfg.index))
                pngu_pkg::CFG_BPP:     bpp_reg     <= cfg.data[pngu_pkg::BPP_W-1:0];
                pngu_pkg::CFG_ROW_LEN: row_len_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ request decoding
    assign advance   = stg_valid_reg && (!pix_valid_reg || pix.ready);
    assign raw.ready = !stg_valid_reg || advance;
    assign accept    = raw.valid && raw.ready;

    assign eff_halted = halted_reg && !raw.image_start;
    assign eff_expect = expect_reg || raw.image_start;
    assign eff_first  = first_row_reg || raw.image_start;

    always_comb
    begin
        if (bpp_reg == '0)
            bpp_c = pngu_pkg::BPP_W'(1);
        else if (bpp_reg > pngu_pkg::BPP_W'(4))
            bpp_c = pngu_pkg::BPP_W'(4);
        else
            bpp_c = bpp_reg;

        len_ext = LW'(row_len_reg);
        if (len_ext == '0)
            len_c = LW'(1);
        else if (len_ext > LW'(MAX_ROW_BYTES))
            len_c = LW'(MAX_ROW_BYTES);
        else
            len_c = len_ext;
    end

    assign x_plus = LW'(col_reg) + LW'(1);
    assign last_c = x_plus >= len_c;

    always_comb
    begin
        halted_next    = halted_reg && !raw.image_start;
        expect_next    = eff_expect;
        first_row_next = eff_first;
        filter_next    = filter_reg;
        col_next       = col_reg;
        stg_load       = 1'b0;

        stg_next.is_data   = 1'b0;
        stg_next.raw_byte  = raw.raw_byte;
        stg_next.filt      = filter_reg;
        stg_next.x         = col_reg;
        stg_next.last      = last_c;
        stg_next.first_row = first_row_reg;
        stg_next.use_left  = AW'(bpp_c) <= col_reg;
        stg_next.sel       = 2'(bpp_c - pngu_pkg::BPP_W'(1));

        priority if (eff_halted)
        begin
            expect_next    = expect_reg;
            first_row_next = first_row_reg;
        end
        else if (eff_expect)
        begin
            if (raw.raw_byte > BW'(pngu_pkg::FILT_PAETH))
            begin
                halted_next = 1'b1;
                stg_load    = 1'b1;
            end
            else
            begin
                filter_next = pngu_pkg::filter_t'(raw.raw_byte[2:0]);
                expect_next = 1'b0;
                col_next    = '0;
            end
        end
        else
        begin
            stg_load         = 1'b1;
            stg_next.is_data = 1'b1;
            if (last_c)
            begin
                expect_next    = 1'b1;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end

        if (!accept)
        begin
            halted_next    = halted_reg;
            expect_next    = expect_reg;
            first_row_next = first_row_reg;
            filter_next    = filter_reg;
            col_next       = col_reg;
            stg_load       = 1'b0;
        end
    end

    assign stg_valid_next = stg_load || (stg_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            expect_reg    <= 1'b1;
            first_row_reg <= 1'b1;
            filter_reg    <= pngu_pkg::FILT_NONE;
            col_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            halted_reg    <= halted_next;
            expect_reg    <= expect_next;
            first_row_reg <= first_row_next;
            filter_reg    <= filter_next;
            col_reg       <= col_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_load)
            stg_reg <= stg_next;
    end

    // --------------------------------------------------------- prior row RAM
    always_ff @(posedge clk)
    begin
        if (stg_load && stg_next.is_data)
            rd_data_reg <= prior_row[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (advance && stg_reg.is_data)
            prior_row[stg_reg.x] <= val;
    end

    // -------------------------------------------------------- reconstruction
    assign up_b      = stg_reg.first_row ? '0 : rd_data_reg;
    assign left_b    = stg_reg.use_left ? left_bytes_reg[{stg_reg.sel, 3'b000} +: BW] : '0;
    assign up_left_b = stg_reg.use_left ? up_left_bytes_reg[{stg_reg.sel, 3'b000} +: BW] : '0;

    assign avg_sum = {1'b0, left_b} + {1'b0, up_b};
    assign ab_sum  = {2'b00, left_b} + {2'b00, up_b};
    assign cc_sum  = {1'b0, up_left_b, 1'b0};

    always_comb
    begin
        pa = (up_b >= up_left_b) ? up_b - up_left_b : up_left_b - up_b;
        pb = (left_b >= up_left_b) ? left_b - up_left_b : up_left_b - left_b;
        pc = (ab_sum >= cc_sum) ? ab_sum - cc_sum : cc_sum - ab_sum;
        if ((BW+2)'(pa) <= (BW+2)'(pb) && (BW+2)'(pa) <= pc)
            paeth = left_b;
        else if ((BW+2)'(pb) <= pc)
            paeth = up_b;
        else
            paeth = up_left_b;
    end

    always_comb
    begin
        unique case (stg_reg.filt)
            pngu_pkg::FILT_NONE:  pred = '0;
            pngu_pkg::FILT_SUB:   pred = left_b;
            pngu_pkg::FILT_UP:    pred = up_b;
            pngu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
            pngu_pkg::FILT_PAETH: pred = paeth;
            default:              pred = '0;
        endcase
    end

    assign val = stg_reg.raw_byte + pred;

    always_ff @(posedge clk)
    begin
        if (advance && stg_reg.is_data)
        begin
            left_bytes_reg    <= {left_bytes_reg[23:0], val};
            up_left_bytes_reg <= {up_left_bytes_reg[23:0], up_b};
        end
    end

    // ------------------------------------------------------- output register
    assign pix_valid_next = advance || (pix_valid_reg && !pix.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_byte_reg <= stg_reg.is_data ? val : '0;
            pix_end_reg  <= stg_reg.is_data && stg_reg.last;
            pix_bad_reg  <= !stg_reg.is_data;
        end
    end

    assign pix.valid      = pix_valid_reg;
    assign pix.pixel_byte = pix_byte_reg;
    assign pix.row_end    = pix_end_reg;
    assign pix.bad_filter = pix_bad_reg;

    // ------------------------------------------------------------ assertions
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, stg_valid_reg && !advance, stg_valid_reg)
    `ASSERT_NEXT(a_error_halts, clk, rst_n, stg_load && !stg_next.is_data, halted_reg)
    `ASSERT_IMPLIES(a_no_ram_clash, clk, rst_n,
        stg_load && stg_next.is_data && advance && stg_reg.is_data, col_reg != stg_reg.x)
    `ASSERT_IMPLIES(a_bad_is_blank, clk, rst_n, pix_valid_reg && pix_bad_reg,
        pix_byte_reg == '0 && !pix_end_reg)

endmodule
